// File: hdl/gcbf_pkg.sv
`default_nettype none

package gcbf_pkg;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    localparam logic [2:0] REG_DRY_GAS    = 3'd0;
    localparam logic [2:0] REG_VAPOUR_GAS = 3'd1;
    localparam logic [2:0] REG_AMBIENT_P  = 3'd2;
    localparam logic [2:0] REG_BASE_T     = 3'd3;
    localparam logic [2:0] REG_BASE_Y     = 3'd4;
    localparam logic [2:0] REG_INFLOW_U   = 3'd5;
    localparam logic [2:0] REG_INFLOW_V   = 3'd6;
    localparam logic [2:0] REG_INFLOW_T   = 3'd7;

    localparam logic [30:0]        RST_DRY_GAS    = 31'd18812109;
    localparam logic [30:0]        RST_VAPOUR_GAS = 31'd30244864;
    localparam logic [30:0]        RST_AMBIENT_P  = 31'd66404352;
    localparam logic [30:0]        RST_BASE_T     = 31'd24455578;
    localparam logic [16:0]        RST_BASE_Y     = 17'd65536;
    localparam logic signed [31:0] RST_INFLOW_U   = 32'sd655360;
    localparam logic signed [31:0] RST_INFLOW_V   = 32'sd0;
    localparam logic [30:0]        RST_INFLOW_T   = 31'd19660800;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] Q16_ONE = 48'sd65536;

    localparam int DIV_STEPS = 31;

    typedef struct packed {
        logic [1:0]         side;
        logic [9:0]         position;
        logic signed [31:0] u_first;
        logic signed [31:0] v_first;
        logic signed [31:0] temp_first;
        logic signed [31:0] press_first;
        logic signed [31:0] frac_first;
        logic signed [31:0] u_second;
        logic signed [31:0] v_second;
        logic signed [31:0] press_second;
    } item_t;

    typedef struct packed {
        logic [1:0]         side_out;
        logic [9:0]         position_out;
        logic               ghost_layer;
        logic signed [31:0] density;
        logic signed [31:0] u_ghost;
        logic signed [31:0] v_ghost;
        logic signed [31:0] temp_ghost;
        logic signed [31:0] press_ghost;
        logic signed [31:0] frac_ghost;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [30:0]        dry_gas_constant;
        logic [30:0]        vapour_gas_constant;
        logic [30:0]        ambient_pressure;
        logic [30:0]        base_temperature;
        logic [16:0]        base_mass_fraction;
        logic signed [31:0] inflow_u;
        logic signed [31:0] inflow_v;
        logic [30:0]        inflow_temperature;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         side;
        logic [9:0]         position;
        logic               layer;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] t;
        logic signed [31:0] p;
        logic signed [31:0] y;
    } ghost_t;

    typedef struct packed {
        ghost_t      g;
        logic [63:0] rem;
        logic [62:0] dvs;
        logic [30:0] quo;
        logic        neg;
        logic        zero;
        logic        ovf;
    } div_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sd2147483647)
        begin
            r = S32_MAX;
        end
        else if (x < -48'sd2147483648)
        begin
            r = S32_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ghost_cell_boundary_fill_unit.sv
// Each item with a position below GRID_EXTENT issues two ghosts, near (layer 0) then far
// (layer 1), into a 37-stage pipeline (two multipliers, then a 31-stage restoring divider).
// Throughput: one result per cycle while the output is not stalled; a new item is taken
// as the last one's far ghost issues. A stalled output freezes the whole pipeline.
// Reset: asynchronous, active low; clears valid state and loads the register defaults.
`default_nettype none

module ghost_cell_boundary_fill_unit
    import gcbf_pkg::*;
#(
    parameter int unsigned GRID_EXTENT = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             ghost_valid,
    input  wire logic        ghost_stall,
    output result_t          ghost,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t out_reg, out_next;
    logic    adv;
    logic    a_valid, e_valid, q_valid;
    ghost_t  a_ghost;
    div_t    e_div, q_div;

    assign adv = !out_valid_reg || !ghost_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry_gas_constant    <= RST_DRY_GAS;
            cfg_reg.vapour_gas_constant <= RST_VAPOUR_GAS;
            cfg_reg.ambient_pressure    <= RST_AMBIENT_P;
            cfg_reg.base_temperature    <= RST_BASE_T;
            cfg_reg.base_mass_fraction  <= RST_BASE_Y;
            cfg_reg.inflow_u            <= RST_INFLOW_U;
            cfg_reg.inflow_v            <= RST_INFLOW_V;
            cfg_reg.inflow_temperature  <= RST_INFLOW_T;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DRY_GAS:    cfg_reg.dry_gas_constant    <= cfg_data[30:0];
                REG_VAPOUR_GAS: cfg_reg.vapour_gas_constant <= cfg_data[30:0];
                REG_AMBIENT_P:  cfg_reg.ambient_pressure    <= cfg_data[30:0];
                REG_BASE_T:     cfg_reg.base_temperature    <= cfg_data[30:0];
                REG_BASE_Y:     cfg_reg.base_mass_fraction  <= cfg_data[16:0];
                REG_INFLOW_U:   cfg_reg.inflow_u            <= $signed(cfg_data);
                REG_INFLOW_V:   cfg_reg.inflow_v            <= $signed(cfg_data);
                REG_INFLOW_T:   cfg_reg.inflow_temperature  <= cfg_data[30:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    gcbf_issue #(
        .GRID_EXTENT (GRID_EXTENT)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .adv        (adv),
        .cfg        (cfg_reg),
        .item_stall (item_stall),
        .a_valid    (a_valid),
        .a_ghost    (a_ghost)
    );

    gcbf_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg_reg),
        .a_valid (a_valid),
        .a_ghost (a_ghost),
        .e_valid (e_valid),
        .e_div   (e_div)
    );

    gcbf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .e_valid (e_valid),
        .e_div   (e_div),
        .q_valid (q_valid),
        .q_div   (q_div)
    );

    always_comb
    begin
        out_next.side_out     = q_div.g.side;
        out_next.position_out = q_div.g.position;
        out_next.ghost_layer  = q_div.g.layer;
        out_next.u_ghost      = q_div.g.u;
        out_next.v_ghost      = q_div.g.v;
        out_next.temp_ghost   = q_div.g.t;
        out_next.press_ghost  = q_div.g.p;
        out_next.frac_ghost   = q_div.g.y;
        out_next.last         = q_div.g.layer;
        if (q_div.zero)
        begin
            if (q_div.g.p[31])
            begin
                out_next.density = S32_MIN;
            end
            else if (q_div.g.p != 32'sd0)
            begin
                out_next.density = S32_MAX;
            end
            else
            begin
                out_next.density = 32'sd0;
            end
        end
        else if (q_div.ovf)
        begin
            out_next.density = q_div.neg ? S32_MIN : S32_MAX;
        end
        else if (q_div.neg)
        begin
            out_next.density = -$signed({1'b0, q_div.quo});
        end
        else
        begin
            out_next.density = $signed({1'b0, q_div.quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign ghost_valid = out_valid_reg;
    assign ghost       = out_reg;

endmodule

`default_nettype wire

// File: hdl/gcbf_issue.sv
`default_nettype none

module gcbf_issue
    import gcbf_pkg::*;
#(
    parameter int unsigned GRID_EXTENT = 1024
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    input  wire item_t  item,
    input  wire logic   adv,
    input  wire cfg_t   cfg,
    output logic        item_stall,
    output logic        a_valid,
    output ghost_t      a_ghost
);

    item_t  hold_reg;
    logic   hold_valid_reg, hold_valid_next;
    logic   layer_reg, layer_next;
    logic   a_valid_reg;
    ghost_t a_ghost_reg;

    logic   take, finish, accept, in_range;
    ghost_t sel;
    logic signed [47:0] t_mir, y_mir;

    assign take       = hold_valid_reg && adv;
    assign finish     = take && layer_reg;
    assign item_stall = hold_valid_reg && !finish;
    assign accept     = item_valid && !item_stall;
    assign in_range   = 32'(item.position) < GRID_EXTENT;

    always_comb
    begin
        hold_valid_next = (hold_valid_reg && !finish) || (accept && in_range);
        if (accept)
        begin
            layer_next = 1'b0;
        end
        else if (take)
        begin
            layer_next = 1'b1;
        end
        else
        begin
            layer_next = layer_reg;
        end
    end

    always_comb
    begin
        t_mir = $signed({16'd0, cfg.base_temperature, 1'b0}) - 48'(hold_reg.temp_first);
        y_mir = $signed({30'd0, cfg.base_mass_fraction, 1'b0}) - 48'(hold_reg.frac_first);
        sel.side     = hold_reg.side;
        sel.position = hold_reg.position;
        sel.layer    = layer_reg;
        case (hold_reg.side)
            SIDE_LEFT:
            begin
                sel.u = cfg.inflow_u;
                sel.v = cfg.inflow_v;
                sel.t = $signed({1'b0, cfg.inflow_temperature});
                sel.p = hold_reg.press_first;
                sel.y = 32'sd0;
            end
            SIDE_BOTTOM:
            begin
                sel.u = sat32(-48'(layer_reg ? hold_reg.u_second : hold_reg.u_first));
                sel.v = sat32(-48'(layer_reg ? hold_reg.v_second : hold_reg.v_first));
                sel.t = sat32(t_mir);
                sel.p = layer_reg ? hold_reg.press_second : hold_reg.press_first;
                if (y_mir < 48'sd0)
                begin
                    sel.y = 32'sd0;
                end
                else if (y_mir > Q16_ONE)
                begin
                    sel.y = Q16_ONE[31:0];
                end
                else
                begin
                    sel.y = y_mir[31:0];
                end
            end
            default:
            begin
                sel.u = hold_reg.u_first;
                sel.v = hold_reg.v_first;
                sel.t = hold_reg.temp_first;
                sel.p = $signed({1'b0, cfg.ambient_pressure});
                sel.y = hold_reg.frac_first;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            layer_reg      <= 1'b0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            layer_reg      <= layer_next;
            if (adv)
            begin
                a_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= item;
        end
        if (adv)
        begin
            a_ghost_reg <= sel;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_ghost = a_ghost_reg;

endmodule

`default_nettype wire

// File: hdl/gcbf_mix.sv
`default_nettype none

module gcbf_mix
    import gcbf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire cfg_t   cfg,
    input  wire logic   a_valid,
    input  wire ghost_t a_ghost,
    output logic        e_valid,
    output div_t        e_div
);

    logic               b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    ghost_t             b_ghost_reg, c_ghost_reg, d_ghost_reg;
    logic signed [63:0] b_prod_reg;
    logic signed [31:0] c_rmix_reg;
    logic signed [63:0] d_den_reg;
    div_t               e_div_reg;

    logic signed [31:0] diff;
    logic signed [47:0] rsum;
    logic [63:0]        dmag;
    logic [32:0]        pmag;
    logic [63:0]        rem0;
    div_t               e_next;

    assign diff = $signed({1'b0, cfg.vapour_gas_constant}) - $signed({1'b0, cfg.dry_gas_constant});
    assign rsum = $signed({17'd0, cfg.dry_gas_constant}) + $signed(b_prod_reg[63:16]);

    always_comb
    begin
        dmag = d_den_reg[63] ? 64'(-d_den_reg) : 64'(d_den_reg);
        pmag = d_ghost_reg.p[31] ? 33'(-33'(d_ghost_reg.p)) : 33'(d_ghost_reg.p);
        rem0 = {22'd0, pmag, 9'd0};
        e_next.g    = d_ghost_reg;
        e_next.rem  = rem0;
        e_next.dvs  = dmag[62:0];
        e_next.quo  = '0;
        e_next.neg  = d_ghost_reg.p[31] ^ d_den_reg[63];
        e_next.zero = (d_den_reg == 64'sd0);
        e_next.ovf  = (rem0 >= {1'b0, dmag[62:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_ghost_reg <= a_ghost;
            b_prod_reg  <= a_ghost.y * diff;
            c_ghost_reg <= b_ghost_reg;
            c_rmix_reg  <= sat32(rsum);
            d_ghost_reg <= c_ghost_reg;
            d_den_reg   <= c_rmix_reg * c_ghost_reg.t;
            e_div_reg   <= e_next;
        end
    end

    assign e_valid = e_valid_reg;
    assign e_div   = e_div_reg;

endmodule

`default_nettype wire

// File: hdl/gcbf_div.sv
`default_nettype none

module gcbf_div
    import gcbf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic e_valid,
    input  wire div_t e_div,
    output logic      q_valid,
    output div_t      q_div
);

    logic stg_valid_reg [DIV_STEPS];
    div_t stg_reg       [DIV_STEPS];

    function automatic div_t div_step(input div_t s);
        div_t        o;
        logic [63:0] r2;
        o  = s;
        r2 = {s.rem[62:0], 1'b0};
        if (r2 >= {1'b0, s.dvs})
        begin
            o.rem = r2 - {1'b0, s.dvs};
            o.quo = {s.quo[29:0], 1'b1};
        end
        else
        begin
            o.rem = r2;
            o.quo = {s.quo[29:0], 1'b0};
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                stg_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            stg_valid_reg[0] <= e_valid;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                stg_valid_reg[k] <= stg_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0] <= div_step(e_div);
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                stg_reg[k] <= div_step(stg_reg[k-1]);
            end
        end
    end

    assign q_valid = stg_valid_reg[DIV_STEPS-1];
    assign q_div   = stg_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/gcbf_checker.sv
`default_nettype none

module gcbf_checker
    import gcbf_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    ghost_valid,
    input wire logic    ghost_stall,
    input wire result_t ghost
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && ghost_stall |=> ghost_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && ghost_stall |=> $stable(ghost))
        else $error("stalled result changed");

    a_left_dry: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && ghost.side_out == SIDE_LEFT |-> ghost.frac_ghost == 32'sd0)
        else $error("inflow ghost carries vapour");

    a_wall_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && ghost.side_out == SIDE_BOTTOM
        |-> !ghost.frac_ghost[31] && ghost.frac_ghost <= 32'sd65536
            && ghost.last == ghost.ghost_layer)
        else $error("wall ghost fraction out of range");

endmodule

bind ghost_cell_boundary_fill_unit gcbf_checker u_gcbf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ghost_valid (ghost_valid),
    .ghost_stall (ghost_stall),
    .ghost       (ghost)
);

`default_nettype wire

// File: bench/ghost_cell_boundary_fill_unit_tb.sv
`timescale 1ns / 1ps

module ghost_cell_boundary_fill_unit_tb;
    import gcbf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        ghost_valid;
    logic        ghost_stall = 1'b0;
    result_t     ghost;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = REG_DRY_GAS;
    logic [31:0] cfg_data = '0;

    ghost_cell_boundary_fill_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .ghost_valid(ghost_valid), .ghost_stall(ghost_stall), .ghost(ghost),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the register file
    longint r_dry, r_vap, r_amb, r_base_t, r_base_y, r_in_u, r_in_v, r_in_t;

    result_t pending_ghosts[$];
    int      error_count = 0;
    bit      calm = 1'b0;

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic logic signed [31:0] density_q824(longint p, longint y, longint t);
        longint     rmix;
        longint     d;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        bit         neg;
        rmix = clip32(r_dry + ((y * (r_vap - r_dry)) >>> 16));
        d = rmix * t;
        if (d == 0)
        begin
            return p > 0 ? S32_MAX : (p < 0 ? S32_MIN : 32'sd0);
        end
        neg = (p < 0) != (d < 0);
        num = 128'(p < 0 ? -p : p);
        num = num << 40;
        den = 128'(d < 0 ? -d : d);
        q = num / den;
        if (q > 128'h8000_0000)
        begin
            return neg ? S32_MIN : S32_MAX;
        end
        if (neg)
        begin
            return 32'(-longint'(q[63:0]));
        end
        if (q > 128'h7FFF_FFFF)
        begin
            return S32_MAX;
        end
        return q[31:0];
    endfunction

    function automatic result_t ghost_for(item_t it, bit layer);
        result_t r;
        longint  u, v, t, p, y;
        case (it.side)
            SIDE_LEFT:
            begin
                u = r_in_u; v = r_in_v; t = r_in_t; p = it.press_first; y = 0;
            end
            SIDE_BOTTOM:
            begin
                t = clip32(2 * r_base_t - longint'(it.temp_first));
                y = 2 * r_base_y - longint'(it.frac_first);
                if (y < 0) y = 0;
                if (y > 65536) y = 65536;
                u = clip32(-longint'(layer ? it.u_second : it.u_first));
                v = clip32(-longint'(layer ? it.v_second : it.v_first));
                p = layer ? it.press_second : it.press_first;
            end
            default:
            begin
                u = it.u_first; v = it.v_first; t = it.temp_first;
                p = r_amb; y = it.frac_first;
            end
        endcase
        r.side_out     = it.side;
        r.position_out = it.position;
        r.ghost_layer  = layer;
        r.density      = density_q824(p, y, t);
        r.u_ghost      = u[31:0];
        r.v_ghost      = v[31:0];
        r.temp_ghost   = t[31:0];
        r.press_ghost  = p[31:0];
        r.frac_ghost   = y[31:0];
        r.last         = layer;
        return r;
    endfunction

    task automatic reset_shadow();
        r_dry = RST_DRY_GAS;  r_vap = RST_VAPOUR_GAS; r_amb = RST_AMBIENT_P;
        r_base_t = RST_BASE_T; r_base_y = RST_BASE_Y;
        r_in_u = RST_INFLOW_U; r_in_v = RST_INFLOW_V; r_in_t = RST_INFLOW_T;
    endtask

    // one transfer on the item channel; predicts both ghosts at acceptance
    task automatic send_item(item_t it);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        if (int'(it.position) < 1024)
        begin
            pending_ghosts.push_back(ghost_for(it, 1'b0));
            pending_ghosts.push_back(ghost_for(it, 1'b1));
        end
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        while (pending_ghosts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_DRY_GAS:    r_dry    = val[30:0];
            REG_VAPOUR_GAS: r_vap    = val[30:0];
            REG_AMBIENT_P:  r_amb    = val[30:0];
            REG_BASE_T:     r_base_t = val[30:0];
            REG_BASE_Y:     r_base_y = val[16:0];
            REG_INFLOW_U:   r_in_u   = longint'(signed'(val));
            REG_INFLOW_V:   r_in_v   = longint'(signed'(val));
            default:        r_in_t   = val[30:0];
        endcase
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'($urandom_range(0, 131072)) - 32'd65536;
            5, 6: return 32'($urandom_range(0, 100_000_000));
            default: return $urandom();
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.side         = 2'($urandom_range(0, 3));
        it.position     = 10'($urandom());
        it.u_first      = pick_word();
        it.v_first      = pick_word();
        it.temp_first   = $urandom_range(0, 3) == 0 ? pick_word()
                                                    : 32'($urandom_range(1 << 20, 1 << 26));
        it.press_first  = pick_word();
        it.frac_first   = $urandom_range(0, 1) == 0 ? pick_word()
                                                    : 32'($urandom_range(0, 65536));
        it.u_second     = pick_word();
        it.v_second     = pick_word();
        it.press_second = pick_word();
        return it;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && ghost_valid && !ghost_stall)
        begin
            if (pending_ghosts.size() == 0)
            begin
                $error("ghost transfer with nothing expected");
                error_count++;
            end
            else
            begin
                e = pending_ghosts.pop_front();
                check_field("side_out", e.side_out, ghost.side_out);
                check_field("position_out", e.position_out, ghost.position_out);
                check_field("ghost_layer", e.ghost_layer, ghost.ghost_layer);
                check_field("density", e.density, ghost.density);
                check_field("u_ghost", e.u_ghost, ghost.u_ghost);
                check_field("v_ghost", e.v_ghost, ghost.v_ghost);
                check_field("temp_ghost", e.temp_ghost, ghost.temp_ghost);
                check_field("press_ghost", e.press_ghost, ghost.press_ghost);
                check_field("frac_ghost", e.frac_ghost, ghost.frac_ghost);
                check_field("last", e.last, ghost.last);
            end
        end
    end

    // output back-pressure in bursts
    always @(negedge clk)
    begin
        if (calm)
        begin
            ghost_stall <= 1'b0;
        end
        else if (ghost_stall == 1'b0 && $urandom_range(0, 5) == 0)
        begin
            ghost_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            ghost_stall <= 1'b0;
        end
    end

    task automatic test_sides_extremes();
        item_t it;
        for (int s = 0; s < 4; s++)
        begin
            for (int k = 0; k < 5; k++)
            begin
                it = random_item();
                it.side = 2'(s);
                it.position = k[0] ? 10'd1023 : 10'd0;
                if (k == 1)
                begin
                    {it.u_first, it.v_first, it.temp_first, it.press_first} = {4{S32_MIN}};
                    {it.frac_first, it.u_second, it.v_second, it.press_second} = {4{S32_MIN}};
                end
                if (k == 2)
                begin
                    {it.u_first, it.v_first, it.temp_first, it.press_first} = {4{S32_MAX}};
                    {it.frac_first, it.u_second, it.v_second, it.press_second} = {4{S32_MAX}};
                end
                if (k == 3)
                begin
                    it.temp_first = '0;
                    it.press_first = '0;
                end
                send_item(it);
            end
        end
    endtask

    task automatic test_register_extremes();
        logic [31:0] lo_hi[2] = '{32'h0, 32'hFFFF_FFFF};
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                write_reg(3'(r), lo_hi[pass]);
            end
            repeat (12) send_item(random_item());
        end
        write_reg(REG_INFLOW_U, 32'h8000_0000);
        write_reg(REG_INFLOW_V, 32'h7FFF_FFFF);
        write_reg(REG_BASE_Y, 32'd65536);
        write_reg(REG_DRY_GAS, 32'd18812109);
        write_reg(REG_VAPOUR_GAS, 32'd18812109);
        repeat (12) send_item(random_item());
    endtask

    task automatic test_random_settings(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 400 == 0)
            begin
                for (int r = 0; r < 8; r++)
                begin
                    write_reg(3'(r), $urandom_range(0, 1) ? pick_word()
                                                          : 32'($urandom_range(1 << 16, 1 << 26)));
                end
            end
            send_item(random_item());
        end
    endtask

    task automatic test_defaults_steady(int count);
        for (int r = 0; r < 8; r++)
        begin
            write_reg(3'(r), 32'h0);
        end
        write_reg(REG_DRY_GAS, RST_DRY_GAS);
        write_reg(REG_VAPOUR_GAS, RST_VAPOUR_GAS);
        write_reg(REG_AMBIENT_P, RST_AMBIENT_P);
        write_reg(REG_BASE_T, RST_BASE_T);
        write_reg(REG_BASE_Y, RST_BASE_Y);
        write_reg(REG_INFLOW_U, RST_INFLOW_U);
        write_reg(REG_INFLOW_V, RST_INFLOW_V);
        write_reg(REG_INFLOW_T, RST_INFLOW_T);
        calm = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            send_item(random_item());
        end
    endtask

    initial
    begin
        reset_shadow();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_sides_extremes();
        test_register_extremes();
        test_random_settings(1600);
        test_defaults_steady(400);
        while (pending_ghosts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (60) @(negedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: ghost_cell_boundary_fill_unit.f
hdl/gcbf_pkg.sv
hdl/gcbf_issue.sv
hdl/gcbf_mix.sv
hdl/gcbf_div.sv
hdl/ghost_cell_boundary_fill_unit.sv
hdl/gcbf_checker.sv
bench/ghost_cell_boundary_fill_unit_tb.sv
